// ----- hdl/tat_pkg.sv -----
// Package for the thermistor temperature block: widths, register indexes, constants.
// No dependencies.
`default_nettype none
package tat_pkg;
   localparam int SAMPLE_W  = 10;
   localparam int RES_W     = 30;
   localparam int TEMP_W    = 18;
   localparam int VOLT_W    = 9;
   localparam logic [9:0]  ADC_FULL = 10'd1023;
   localparam logic [29:0] R_MAX    = 30'd1022000000;
   localparam logic signed [17:0] T_MIN = -18'sd27315;
   localparam logic signed [17:0] T_MAX = 18'sd100000;
   localparam logic [31:0] LN2_Q30  = 32'd744261118;
   localparam logic [1:0] REG_R0    = 2'd0;
   localparam logic [1:0] REG_T0    = 2'd1;
   localparam logic [1:0] REG_BETA  = 2'd2;

   typedef struct packed {
      logic [19:0] r0;
      logic [15:0] t0;
      logic [14:0] beta;
   } cfg_type;
endpackage
`default_nettype wire

// ----- hdl/tat_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing but its ports.
`default_nettype none
module tat_divider #(
   parameter int NW = 64,
   parameter int DW = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quot
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   // shift in one numerator bit, subtract when it fits
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in = {q_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in[0] = 1'b1;
         end else begin
            r_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ----- hdl/tat_log.sv -----
// Q16 natural logarithm by repeated squaring, one fraction bit per cycle.
// Depends on tat_pkg.
`default_nettype none
module tat_log (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [9:0]  n,
   output logic             done,
   output logic [18:0]      ln_q16
);
   import tat_pkg::*;
   localparam logic [2:0] S_IDLE = 3'd0, S_SQ = 3'd1, S_MUL = 3'd2, S_FIN = 3'd3;
   logic [2:0]  st_ff, st_in;
   logic [31:0] m_ff, m_in;
   logic [3:0]  e_ff, e_in;
   logic [19:0] f_ff, f_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [56:0] prod_ff, prod_in;
   logic        done_ff, done_in;
   logic [63:0] sq;
   logic [3:0]  e0;

   // leading one position of n, capped at nine
   always_comb begin
      e0 = 4'd0;
      for (int i = 1; i < 10; i++)
         if (n[i]) e0 = 4'(i);
   end

   always_comb begin
      st_in = st_ff; m_in = m_ff; e_in = e_ff; f_in = f_ff; cnt_in = cnt_ff;
      prod_in = prod_ff; done_in = 1'b0;
      sq = 64'(m_ff) * 64'(m_ff);
      unique case (st_ff)
         S_IDLE: if (start) begin
            e_in = e0; m_in = 32'({22'd0, n} << (5'd30 - 5'(e0)));
            f_in = '0; cnt_in = 5'd20; st_in = S_SQ;
         end
         S_SQ: begin
            if (sq[63:30] >= 34'h80000000) begin
               m_in = 32'(sq[63:31]); f_in = {f_ff[18:0], 1'b1};
            end else begin
               m_in = 32'(sq[63:30]); f_in = {f_ff[18:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 5'd1) st_in = S_MUL;
         end
         S_MUL: begin
            prod_in = 57'({e_ff, f_ff}) * 57'(LN2_Q30);
            st_in = S_FIN;
         end
         S_FIN: begin
            done_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         st_ff <= st_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      m_ff <= m_in; e_ff <= e_in; f_ff <= f_in; prod_ff <= prod_in;
   end

   assign done   = done_ff;
   assign ln_q16 = prod_ff[52:34];
endmodule
`default_nettype wire

// ----- hdl/thermistor_adc_temperature.sv -----
// Top level of the thermistor temperature block: history, sequencer, output register.
// Depends on tat_pkg, tat_log and tat_divider.
//
// channel  direction  handshake            payload
// req      in         req_tvalid/tready    tdata: sample[9:0]
// rsp      out        rsp_tvalid/tready    tdata: average, resistance, temp, volt, flag
// csr      in         psel/penable/pready  three registers at 4*i
//
// An item runs up to four 64-step serial divisions (mean, resistance, temperature, voltage)
// and two 20-step logarithm passes, one after another on the shared units; at the rails
// only the mean and voltage divisions run.
// Synchronous reset clears history, sum, registers to their defaults and the sequencer.
// A new item is taken while a finished result still waits in the output register; the
// sequencer holds only at the end of that next item until the register is free.
`default_nettype none
module thermistor_adc_temperature #(
   parameter int WINDOW = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // sample[9:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // average[9:0], resistance_ohm[39:10], temp_centi_c[57:40], volt_centi[66:58],
   // out_of_range[67]
   output logic [71:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import tat_pkg::*;
   localparam int SW = $clog2(1023 * WINDOW + 1);
   localparam int HW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [3:0] S_IDLE = 4'd0, S_SUM = 4'd1, S_AVG = 4'd2, S_RES = 4'd3,
      S_LOGA = 4'd4, S_LOGB = 4'd5, S_DEN = 4'd6, S_MULA = 4'd7, S_MULB = 4'd8,
      S_TDIV = 4'd9, S_VOLT = 4'd10, S_OUT = 4'd11, S_WAIT = 4'd12, S_RDIV = 4'd13,
      S_TST = 4'd14;

   cfg_type cfg_ff;
   logic [9:0]  hist_ff [WINDOW];
   logic [SW-1:0] sum_ff;
   logic [HW-1:0] wp_ff;
   logic [3:0]  st_ff, st_in;
   logic [9:0]  avg_ff;
   logic [29:0] res_ff;
   logic signed [17:0] temp_ff;
   logic [8:0]  volt_ff;
   logic        oor_ff;
   logic signed [19:0] l_ff;
   logic signed [63:0] den_ff, numr_ff;
   logic [29:0] tmp_ff;
   logic        ovalid_ff;
   logic [71:0] odata_ff;
   logic        wr;
   logic [9:0]  avg_new;
   logic [29:0] r_prod;

   // shared serial divider and logarithm
   logic        dv_start, dv_done, lg_start, lg_done;
   logic [63:0] dv_num, dv_den, dv_q;
   logic [9:0]  lg_n;
   logic [18:0] lg_out;

   tat_divider #(.NW(64), .DW(64)) u_div (.clock, .reset, .start(dv_start),
      .num(dv_num), .den(dv_den), .done(dv_done), .quot(dv_q));
   tat_log u_log (.clock, .reset, .start(lg_start), .n(lg_n), .done(lg_done),
      .ln_q16(lg_out));

   // configuration port
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_R0:   csr_prdata = 32'(cfg_ff.r0);
         REG_T0:   csr_prdata = 32'(cfg_ff.t0);
         REG_BETA: csr_prdata = 32'(cfg_ff.beta);
         default:  csr_prdata = '0;
      endcase
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;

   // mean from the divider and the resistance numerator r0*(1023-avg)
   assign avg_new = (dv_q > 64'd1023) ? ADC_FULL : dv_q[9:0];
   assign r_prod  = cfg_ff.r0 * (ADC_FULL - avg_new);

   // sequencer
   logic signed [63:0] temp_full;
   always_comb begin
      st_in = st_ff; dv_start = 1'b0; lg_start = 1'b0;
      dv_num = '0; dv_den = 64'd1; lg_n = avg_ff;
      temp_full = numr_ff[63] ? -$signed(dv_q) : $signed(dv_q);
      unique case (st_ff)
         S_IDLE: if (req_tvalid) st_in = S_SUM;
         S_SUM: begin
            dv_start = 1'b1; dv_num = 64'(sum_ff); dv_den = 64'(WINDOW); st_in = S_AVG;
         end
         S_AVG: if (dv_done) st_in = S_RES;
         S_RES: if (avg_ff == 10'd0 || avg_ff == ADC_FULL) st_in = S_VOLT;
            else if (tmp_ff == 30'd0) st_in = S_LOGA;
            else begin
               dv_start = 1'b1; dv_num = 64'(tmp_ff); dv_den = 64'(avg_ff); st_in = S_RDIV;
            end
         S_RDIV: if (dv_done) st_in = S_LOGA;
         S_LOGA: begin
            lg_start = 1'b1; lg_n = ADC_FULL - avg_ff; st_in = S_LOGB;
         end
         S_LOGB: if (lg_done) begin
            lg_start = 1'b1; lg_n = avg_ff; st_in = S_DEN;
         end
         S_DEN:  if (lg_done) st_in = S_MULA;
         S_MULA: st_in = S_MULB;
         S_MULB: st_in = S_TST;
         S_TST: if (den_ff <= 0) st_in = S_VOLT;
            else begin
               dv_start = 1'b1;
               dv_num = numr_ff[63] ? 64'(-numr_ff) : 64'(numr_ff);
               dv_den = 64'(den_ff); st_in = S_TDIV;
            end
         S_TDIV: if (dv_done) st_in = S_VOLT;
         S_VOLT: begin
            dv_start = 1'b1; dv_num = 64'(avg_ff) * 64'd500; dv_den = 64'd1023;
            st_in = S_OUT;
         end
         S_OUT:  if (dv_done) st_in = S_WAIT;
         S_WAIT: if (!ovalid_ff || rsp_tready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; sum_ff <= '0; wp_ff <= '0; ovalid_ff <= 1'b0;
         cfg_ff.r0 <= 20'd10000; cfg_ff.t0 <= 16'd29815; cfg_ff.beta <= 15'd3950;
         for (int i = 0; i < WINDOW; i++) hist_ff[i] <= '0;
         tmp_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (wr) begin
            unique case (csr_paddr[3:2])
               REG_R0:   cfg_ff.r0   <= csr_pwdata[19:0];
               REG_T0:   cfg_ff.t0   <= csr_pwdata[15:0];
               REG_BETA: cfg_ff.beta <= csr_pwdata[14:0];
               default: ;
            endcase
         end
         // ring buffer update of the window
         if (st_ff == S_IDLE && req_tvalid) begin
            sum_ff <= sum_ff - SW'(hist_ff[wp_ff]) + SW'(req_tdata[9:0]);
            hist_ff[wp_ff] <= req_tdata[9:0];
            wp_ff <= (wp_ff == HW'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
         end
         if (st_ff == S_AVG && dv_done) begin
            avg_ff <= avg_new;
            tmp_ff <= r_prod;
            oor_ff <= 1'b0;
         end
         if (st_ff == S_RES) begin
            if (avg_ff == 10'd0) begin
               oor_ff <= 1'b1; res_ff <= R_MAX; temp_ff <= T_MIN;
            end else if (avg_ff == ADC_FULL) begin
               oor_ff <= 1'b1; res_ff <= '0; temp_ff <= T_MAX;
            end else if (tmp_ff == 30'd0) begin
               res_ff <= '0;
            end
         end
         if (st_ff == S_RDIV && dv_done)
            res_ff <= (dv_q > 64'(R_MAX)) ? R_MAX : dv_q[29:0];
         if (st_ff == S_LOGB && lg_done) l_ff <= 20'(lg_out);
         if (st_ff == S_DEN && lg_done) l_ff <= l_ff - 20'(lg_out);
         // two registered products for the denominator and numerator
         if (st_ff == S_MULA) begin
            den_ff  <= 64'(l_ff) * $signed({48'd0, cfg_ff.t0});
            numr_ff <= $signed(64'(cfg_ff.beta) * 64'd6553600);
         end
         // D = B + l*t0, numerator = (t0 - 27315)*B - 27315*l*t0
         if (st_ff == S_MULB) begin
            den_ff  <= den_ff + numr_ff;
            numr_ff <= ($signed({48'd0, cfg_ff.t0}) - 64'sd27315) * numr_ff
                       - 64'sd27315 * den_ff;
         end
         if (st_ff == S_TST && den_ff <= 0) temp_ff <= T_MAX;
         if (st_ff == S_TDIV && dv_done) begin
            temp_ff <= (temp_full < -64'sd27315) ? T_MIN :
                       (temp_full > 64'sd100000) ? T_MAX : temp_full[17:0];
         end
         if (st_ff == S_OUT && dv_done) volt_ff <= dv_q[8:0];
         // output register, refilled as the waiting item leaves
         if (st_ff == S_WAIT && (!ovalid_ff || rsp_tready)) begin
            odata_ff <= {4'd0, oor_ff, volt_ff, temp_ff, res_ff, avg_ff};
            ovalid_ff <= 1'b1;
         end else if (ovalid_ff && rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

// ----- hdl/tat_checker.sv -----
// Port-level checks for the thermistor temperature block, bound to the top level.
// Uses no package; depends only on its ports.
`default_nettype none
module tat_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic        csr_pready
);
   // a result stays until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp dropped");
   // one item at a time: ready drops once an item is taken
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("req taken while busy");
   // out-of-range flag matches the average extremes
   a_oor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67] == (rsp_tdata[9:0] == 10'd0 || rsp_tdata[9:0] == 10'd1023))
      else $error("flag mismatch");
   a_rdy: assert property (@(posedge clock) csr_pready) else $error("pready low");
endmodule

bind thermistor_adc_temperature tat_checker u_chk (.clock, .reset, .req_tvalid, .req_tready,
   .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_pready);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for thermistor_adc_temperature: random ADC sample stream with
// stalls on both sides, several register settings, results checked against a predictor.
// Depends on tat_pkg and the block under test.
`default_nettype none
module tb;
   import tat_pkg::*;

   localparam int WIN       = 10;
   localparam int DRAIN_CYC = 300;
   localparam int HANG_CYC  = 5000;
   localparam logic [3:0] ADDR_UNUSED = 4'd12;

   typedef struct {
      logic [9:0]         average;
      logic [29:0]        res_ohm;
      logic signed [17:0] temp_cc;
      logic [8:0]         volt_cv;
      logic               oor;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // sample[9:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // average[9:0], resistance_ohm[39:10], temp_centi_c[57:40], volt_centi[66:58],
   // out_of_range[67]
   logic [71:0] rsp_tdata;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   thermistor_adc_temperature #(.WINDOW(WIN)) dut (.*);

   always #4 clock = ~clock;

   // predictor state
   cfg_type     cfg_model;
   int unsigned hist [WIN];
   int unsigned hist_sum;
   reading_type readings_due [$];
   logic [9:0]  samples_todo [$];

   int errors = 0, n_items = 0, n_results = 0, n_writes = 0, idle_cyc = 0;
   int req_gap = 0, rsp_stall = 0;
   bit quiet = 1'b0, req_fired = 1'b0;

   // ln(n) in Q16 via Q20 log2 from repeated squaring
   function automatic longint ln_q16(int unsigned n);
      int unsigned e = 0;
      longint unsigned m;
      longint unsigned frac = 0;
      while (e < 9 && (n >> (e + 1)) != 0) e++;
      m = longint'(n) << (30 - e);
      for (int i = 0; i < 20; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      return longint'((((longint'(e) << 20) | frac) * longint'(LN2_Q30)) >> 34);
   endfunction

   function automatic reading_type predict_reading(logic [9:0] s);
      reading_type r;
      int unsigned avg;
      longint res, l, num, den, t0, b, temp;
      hist_sum = hist_sum - hist[WIN-1] + s;
      for (int i = WIN - 1; i > 0; i--) hist[i] = hist[i-1];
      hist[0] = s;
      avg = hist_sum / WIN;
      if (avg > 1023) avg = 1023;
      if (avg == 0) begin
         res = R_MAX;
         temp = T_MIN;
      end else if (avg == 1023) begin
         res = 0;
         temp = T_MAX;
      end else begin
         res = longint'(cfg_model.r0) * (1023 - avg) / avg;
         if (res > R_MAX) res = R_MAX;
         l = ln_q16(1023 - avg) - ln_q16(avg);
         t0 = cfg_model.t0;
         b = cfg_model.beta;
         num = 100 * t0 * b * 65536;
         den = 100 * b * 65536 + l * t0;
         if (den <= 0) temp = T_MAX;
         else begin
            temp = (num - 27315 * den) / den;
            if (temp < T_MIN) temp = T_MIN;
            if (temp > T_MAX) temp = T_MAX;
         end
      end
      r.average = avg[9:0];
      r.res_ohm = res[29:0];
      r.temp_cc = temp[17:0];
      r.volt_cv = 9'((avg * 500) / 1023);
      r.oor = (avg == 0) || (avg == 1023);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
      errors++;
   endtask

   // sample acceptance, result check, watchdog
   always @(posedge clock) begin
      reading_type want;
      req_fired = req_tvalid && req_tready && !reset;
      if (req_fired) begin
         readings_due.push_back(predict_reading(req_tdata[9:0]));
         n_items++;
      end
      if (rsp_tvalid && rsp_tready && !reset) begin
         if (readings_due.size() == 0) begin
            $display("MISMATCH unexpected result %0h", rsp_tdata);
            errors++;
         end else begin
            want = readings_due.pop_front();
            if (rsp_tdata[9:0] !== want.average)
               report_mismatch("average", rsp_tdata[9:0], want.average);
            if (rsp_tdata[39:10] !== want.res_ohm)
               report_mismatch("resistance", rsp_tdata[39:10], want.res_ohm);
            if (rsp_tdata[57:40] !== want.temp_cc)
               report_mismatch("temperature", $signed(rsp_tdata[57:40]), want.temp_cc);
            if (rsp_tdata[66:58] !== want.volt_cv)
               report_mismatch("voltage", rsp_tdata[66:58], want.volt_cv);
            if (rsp_tdata[67] !== want.oor)
               report_mismatch("out_of_range", rsp_tdata[67], want.oor);
         end
         n_results++;
      end
      if (req_fired || (rsp_tvalid && rsp_tready) || reset) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= HANG_CYC) begin
         $display("timeout after %0d idle cycles", idle_cyc);
         $display("thermistor_adc_temperature test failed");
         $finish;
      end
   end

   // sample driver with random gaps
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_fired)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (samples_todo.size() != 0) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
               req_gap = $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else begin
               req_tdata <= {6'd0, samples_todo.pop_front()};
               req_tvalid <= 1'b1;
            end
         end else req_tvalid <= 1'b0;
      end
   end

   // result-side back-pressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else rsp_tready <= 1'b1;
   end

   task automatic csr_write(logic [3:0] addr, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= addr; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (addr[3:2])
         REG_R0:   cfg_model.r0 = value[19:0];
         REG_T0:   cfg_model.t0 = value[15:0];
         REG_BETA: cfg_model.beta = value[14:0];
         default: ;
      endcase
      n_writes++;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic set_thermistor(int unsigned r0, int unsigned t0, int unsigned beta);
      csr_write({REG_R0, 2'b00}, r0);
      csr_write({REG_T0, 2'b00}, t0);
      csr_write({REG_BETA, 2'b00}, beta);
   endtask

   // let everything drain before touching the registers again
   task automatic wait_drained();
      while (samples_todo.size() != 0 || req_tvalid || readings_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // mostly steady runs so the mean reaches the rails, with noise mixed in
   task automatic queue_random(int count);
      int left = count;
      logic [9:0] level;
      while (left > 0) begin
         case ($urandom_range(0, 3))
            0: level = 10'd0;
            1: level = 10'd1023;
            default: level = $urandom_range(0, 1023);
         endcase
         for (int k = $urandom_range(1, 14); k > 0 && left > 0; k--) begin
            samples_todo.push_back($urandom_range(0, 3) == 0 ? 10'($urandom) : level);
            left--;
         end
      end
   endtask

   initial begin
      cfg_model = '{r0: 20'd10000, t0: 16'd29815, beta: 15'd3950};
      foreach (hist[i]) hist[i] = 0;
      hist_sum = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default registers: rails of the field, all-low and all-high runs, edge means
      samples_todo.push_back(10'd0);
      samples_todo.push_back(10'd9);
      samples_todo.push_back(10'd1);
      repeat (10) samples_todo.push_back(10'd1023);
      samples_todo.push_back(10'd1013);
      samples_todo.push_back(10'd1022);
      repeat (3) samples_todo.push_back(10'd512);
      samples_todo.push_back(10'h155);
      samples_todo.push_back(10'h2AA);
      repeat (5) samples_todo.push_back(10'd0);
      queue_random(200);
      wait_drained();

      // upper extremes, plus a write to an unused slot that must be ignored
      set_thermistor(1000000, 65535, 20000);
      csr_write(ADDR_UNUSED, 32'hFFFF_FFFF);
      queue_random(130);
      wait_drained();

      // lower extremes
      set_thermistor(1, 1, 1);
      queue_random(130);
      wait_drained();

      // random in-range settings, the last stretch with no idling
      set_thermistor($urandom_range(1, 1000000), $urandom_range(1, 65535),
                     $urandom_range(1, 20000));
      queue_random(130);
      wait_drained();
      quiet = 1'b1;
      set_thermistor(20'hFFFFF, $urandom_range(1, 65535), $urandom_range(1, 20000));
      queue_random(130);
      wait_drained();

      $display("covered %0d samples, %0d results, %0d register writes, 5 settings",
               n_items, n_results, n_writes);
      if (errors == 0) $display("thermistor_adc_temperature test passed");
      else $display("thermistor_adc_temperature test failed");
      $finish;
   end
endmodule
`default_nettype wire
